// ----- rtl/mse_pkg.sv -----
// Shared types, codes and fixed-point helpers of the multi-segment envelope unit.
package mse_pkg;

    // Item modes on the input channel.
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_NOTE   = 2'd2;

    // Combine modes; every other code adds.
    localparam logic [1:0] CMB_MUL = 2'd0;
    localparam logic [1:0] CMB_SET = 2'd1;

    // Segment shapes; every other code steps linearly.
    localparam logic [1:0] SHAPE_DECAY = 2'd1;
    localparam logic [1:0] SHAPE_RISE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COMBINE_MODE  = 2'd0;
    localparam logic [1:0] CFG_INITIAL_LEVEL = 2'd1;
    localparam logic [1:0] CFG_SEGMENT_COUNT = 2'd2;

    // 1.0 in unsigned Q7.24.
    localparam logic [30:0] ONE_Q24 = 31'h0100_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] sample;
        logic [3:0]         seg_index;
        logic [23:0]        seg_time;
        logic signed [31:0] seg_target;
        logic signed [31:0] seg_delta;
        logic [30:0]        seg_mult;
        logic [30:0]        seg_scale;
        logic [1:0]         seg_shape;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sample_out;
        logic               finished;
    } t_out_word;

    // One segment table entry without its length.
    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] delta;
        logic [30:0]        mult;
        logic [30:0]        scale;
        logic [1:0]         shape;
    } t_seg_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NOTE,
        ST_ADV,
        ST_ENTER,
        ST_MUL_A,
        ST_MUL_B,
        ST_CURVE,
        ST_DELTA,
        ST_LEVEL,
        ST_OUT
    } t_state;

    // Clamp a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat_q(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh00_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sh00_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q8.24 product: drop 24 fraction bits (floor), then saturate.
    function automatic logic signed [31:0] mul_q(input logic signed [63:0] p);
        logic signed [39:0] q;
        q = p[63:24];
        return sat_q(q);
    endfunction

    // Saturating sum of two Q8.24 values.
    function automatic logic signed [31:0] add_q(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat_q({{7{s[32]}}, s});
    endfunction

    // Saturating difference of a Q8.24 value and an unsigned multiplier.
    function automatic logic signed [31:0] sub_q(input logic signed [31:0] a,
                                                 input logic [30:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {2'b00, b};
        return sat_q({{7{s[32]}}, s});
    endfunction

endpackage

// ----- rtl/multi_segment_envelope_unit.sv -----
// Top level of the multi-segment envelope unit.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one word at a time.
// A load word writes one segment table entry in its accept cycle. A note-start
// word reads segment 0 and loads it in ST_NOTE. A sample word yields exactly one
// result word on the output channel (o_out_valid / i_out_ready / o_out_data),
// which shows in the same cycle as the unit can take its next word. A sample
// word runs ST_MUL_A, ST_MUL_B, ST_OUT on a linear segment, with ST_CURVE,
// ST_DELTA, ST_LEVEL before ST_OUT on a curved one; ST_ADV and ST_ENTER lead
// when it moves to the next segment, ST_ADV then ST_OUT when it ends the last
// segment, and ST_OUT alone once finished. The one shared 32x32 multiplier
// serves the sample combine and both curve products in turn; the segment memory
// read is registered. Mode 3 words are accepted and dropped.
// The result sits in an output register, so the next word is accepted while
// a result waits; a stalled receiver holds the unit only when a second result
// is ready to go out. Configuration writes (i_cfg_*) are always taken.
// Reset sets the control registers and marks the envelope finished; the segment
// table keeps whatever it held and must be loaded before a note starts.
module multi_segment_envelope_unit
    import mse_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int TIME_BITS    = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int AC_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ENT_W = TIME_BITS + $bits(t_seg_entry);

    // Configuration registers.
    logic [1:0]         r_combine;
    logic signed [31:0] r_init_level;
    logic [4:0]         r_seg_count;

    // Envelope state.
    t_state             r_state, n_state;
    logic [AC_W-1:0]    r_active;
    logic [TIME_BITS-1:0] r_frames;
    logic signed [31:0] r_level;
    logic signed [31:0] r_curve;
    logic signed [31:0] r_base;
    logic               r_done;

    // Working registers.
    logic signed [31:0] r_sample;
    logic signed [31:0] r_res;
    logic               r_fin;
    logic signed [63:0] r_prod;
    logic               r_out_valid;
    t_out_word          r_out_data;

    logic               w_acc;
    logic               w_adv;
    logic               w_ld_ok;
    logic               w_curve_shape;
    logic               w_slot_free;
    logic [AC_W-1:0]    w_n;
    logic [AC_W-1:0]    w_s;
    logic [AC_W-1:0]    w_next;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [ENT_W-1:0]   w_wr_data;
    logic [ENT_W-1:0]   w_rd_data;
    t_seg_entry         w_ent;
    t_seg_entry         w_ld_ent;
    logic [TIME_BITS-1:0] w_rd_time;
    logic signed [31:0] w_enter_curve;
    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [31:0] w_combine;

    assign w_acc       = i_in_valid && o_in_ready;
    assign w_adv       = !r_done && (r_frames == '0);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_ld_ok     = ({28'd0, i_in_data.seg_index} < 32'(MAX_SEGMENTS));

    // Segments in use, clamped to one through the table depth.
    always_comb begin
        if (r_seg_count == '0) begin
            w_n = AC_W'(1);
        end else if ({27'd0, r_seg_count} > 32'(MAX_SEGMENTS)) begin
            w_n = AC_W'(MAX_SEGMENTS);
        end else begin
            w_n = AC_W'(r_seg_count);
        end
    end

    assign w_s    = (r_active < w_n) ? r_active : (w_n - AC_W'(1));
    assign w_next = w_s + AC_W'(1);

    // Segment table entry layout: length on top, the rest below.
    assign w_ld_ent.target = i_in_data.seg_target;
    assign w_ld_ent.delta  = i_in_data.seg_delta;
    assign w_ld_ent.mult   = i_in_data.seg_mult;
    assign w_ld_ent.scale  = i_in_data.seg_scale;
    assign w_ld_ent.shape  = i_in_data.seg_shape;
    assign w_wr_data = {TIME_BITS'(i_in_data.seg_time), w_ld_ent};

    assign w_ent     = t_seg_entry'(w_rd_data[$bits(t_seg_entry)-1:0]);
    assign w_rd_time = w_rd_data[ENT_W-1 -: TIME_BITS];

    assign w_curve_shape = (w_ent.shape == SHAPE_DECAY) || (w_ent.shape == SHAPE_RISE);
    assign w_enter_curve = (w_ent.mult > ONE_Q24) ? $signed({1'b0, w_ent.mult})
                                                  : $signed({1'b0, w_ent.scale});

    mse_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW),
        .DW    (ENT_W)
    ) u_seg_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc && (i_in_data.mode == MODE_LOAD) && w_ld_ok),
        .i_wr_addr (AW'(i_in_data.seg_index)),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combine    <= CMB_MUL;
            r_init_level <= '0;
            r_seg_count  <= 5'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COMBINE_MODE:  r_combine    <= i_cfg_data[1:0];
                CFG_INITIAL_LEVEL: r_init_level <= i_cfg_data;
                CFG_SEGMENT_COUNT: r_seg_count  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_in_data.mode == MODE_SAMPLE)) begin
                    if (r_done) begin
                        n_state = ST_OUT;
                    end else if (w_adv) begin
                        n_state = ST_ADV;
                    end else begin
                        n_state = ST_MUL_A;
                    end
                end else if (w_acc && (i_in_data.mode == MODE_NOTE)) begin
                    n_state = ST_NOTE;
                end
            end
            ST_NOTE:  n_state = ST_IDLE;
            ST_ADV:   n_state = (w_next >= w_n) ? ST_OUT : ST_ENTER;
            ST_ENTER: n_state = ST_MUL_A;
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = w_curve_shape ? ST_CURVE : ST_OUT;
            ST_CURVE: n_state = ST_DELTA;
            ST_DELTA: n_state = ST_LEVEL;
            ST_LEVEL: n_state = ST_OUT;
            ST_OUT:   n_state = w_slot_free ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, memory read and multiplier operands.
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_active[AW-1:0];
        w_mul_a    = r_sample;
        w_mul_b    = r_level;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_data.mode == MODE_NOTE) begin
                    w_rd_en   = w_acc;
                    w_rd_addr = '0;
                end else if (i_in_data.mode == MODE_SAMPLE) begin
                    w_rd_en   = w_acc && !r_done;
                    w_rd_addr = w_adv ? w_s[AW-1:0] : r_active[AW-1:0];
                end
            end
            ST_ADV: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_next[AW-1:0];
            end
            ST_MUL_B: begin
                w_mul_a = r_curve;
                w_mul_b = $signed({1'b0, w_ent.mult});
            end
            ST_DELTA: begin
                w_mul_a = sub_q(r_curve, w_ent.mult);
                w_mul_b = w_ent.delta;
            end
            default: ;
        endcase
    end

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // Sample combined with the current level.
    always_comb begin
        case (r_combine)
            CMB_MUL: w_combine = mul_q(r_prod);
            CMB_SET: w_combine = r_level;
            default: w_combine = add_q(r_sample, r_level);
        endcase
    end

    // Sequencer state and envelope state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_frames <= '0;
            r_level  <= '0;
            r_curve  <= '0;
            r_base   <= '0;
            r_done   <= 1'b1;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_NOTE: begin
                    r_active <= '0;
                    r_level  <= r_init_level;
                    r_base   <= r_init_level;
                    r_done   <= 1'b0;
                    r_curve  <= w_enter_curve;
                    r_frames <= w_rd_time;
                end
                ST_ADV: begin
                    r_level <= w_ent.target;
                    if (w_next >= w_n) begin
                        r_active <= w_n;
                        r_done   <= 1'b1;
                    end else begin
                        r_active <= w_next;
                    end
                end
                ST_ENTER: begin
                    r_curve  <= w_enter_curve;
                    r_base   <= r_level;
                    r_frames <= w_rd_time;
                end
                ST_MUL_B: begin
                    if (r_frames != '0) begin
                        r_frames <= r_frames - TIME_BITS'(1);
                    end
                    if (!w_curve_shape) begin
                        r_level <= add_q(r_level, w_ent.delta);
                    end
                end
                ST_CURVE: r_curve <= mul_q(r_prod);
                ST_LEVEL: begin
                    if (w_ent.shape == SHAPE_DECAY) begin
                        r_level <= add_q(w_ent.target, mul_q(r_prod));
                    end else begin
                        r_level <= add_q(mul_q(r_prod), r_base);
                    end
                end
                default: ;
            endcase
        end
    end

    // Result word under construction.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    r_sample <= i_in_data.sample;
                    r_res    <= ((r_combine == CMB_MUL) || (r_combine == CMB_SET))
                                ? '0 : i_in_data.sample;
                    r_fin    <= 1'b1;
                end
            end
            ST_ADV: begin
                r_res <= ((r_combine == CMB_MUL) || (r_combine == CMB_SET)) ? '0 : r_sample;
                r_fin <= 1'b1;
            end
            ST_MUL_B: begin
                r_res <= w_combine;
                r_fin <= 1'b0;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_slot_free) begin
            r_out_data.sample_out <= r_res;
            r_out_data.finished   <= r_fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/mse_seg_mem.sv -----
// Segment table: one write port, one read port with registered read data.
module mse_seg_mem
    import mse_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 152
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/mse_checker.sv -----
// Port-level checks of the multi-segment envelope unit and their binding.
module mse_checker
    import mse_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_word    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_word   o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result word changed while stalled");

    // A sample word keeps the unit busy in the cycle after it is taken.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.mode == MODE_SAMPLE) |=> !o_in_ready)
        else $error("input taken right after a sample word");

    // A table load completes in its accept cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.mode == MODE_LOAD) |=> o_in_ready)
        else $error("unit stalled after a table load");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word offered after reset");

endmodule

bind multi_segment_envelope_unit mse_checker u_mse_checker (.*);
